// ----- rtl/colst_pkg.sv -----
// Package for the circular ordered list store: sizes, command and status
// codes, and the request and response beat types.
// No dependencies; every other file of the block imports it.
package colst_pkg;

   // Store depth and derived widths.
   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 6;
   localparam int SUM_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int DATA_W   = 32;

   // Command codes.
   localparam logic [2:0] CMD_END    = 3'd0;
   localparam logic [2:0] CMD_BEGIN  = 3'd1;
   localparam logic [2:0] CMD_AFTER  = 3'd2;
   localparam logic [2:0] CMD_DELETE = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   // Status codes.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_EMPTY   = 2'd2;
   localparam logic [1:0] STAT_MISSING = 2'd3;

   // Request beat.
   typedef struct packed {
      logic [2:0]              cmd;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]        position;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic signed [DATA_W-1:0] item;
      logic [1:0]              status;
      logic                    last;
   } rsp_type;

endpackage

// ----- rtl/colst_mem.sv -----
// Entry store of the circular ordered list: one write port and one read
// port with registered read data that holds while no read is issued.
// Depends on colst_pkg for depth and widths.
module colst_mem
   import colst_pkg::*;
(
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem_ff [CAPACITY];
   logic signed [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register keeps its value between reads.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/circular_ordered_list_store.sv -----
// Circular ordered list store, top level: sequencer walking the entry store.
// One command at a time; read-out gives one beat per entry. Each walk visits
// one store entry per cycle, and a read-out walk holds while the response
// output stalls. Results wait in an output register.
// Reset (synchronous, active high) empties the list; store contents stay.
module circular_ordered_list_store
   import colst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EMIT,
      S_INS_MOVE,
      S_INS_PUT,
      S_DEL_SCAN,
      S_DEL_MOVE,
      S_RD_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [1:0]               status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] rd_data;

   logic                     out_free;
   logic                     rsp_load;
   rsp_type                  rsp_beat;
   logic                     list_full;
   logic                     at_end;
   logic [IDX_W-1:0]         count_idx;
   logic [SUM_W-1:0]         pos_ext;
   logic [SUM_W-1:0]         cnt_ext;
   logic [SUM_W-1:0]         after_n;
   logic [IDX_W-1:0]         ins_slot;

   colst_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The output register can take a beat when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign list_full = (count_ff == CNT_W'(CAPACITY));
   assign count_idx = IDX_W'(count_ff);
   assign at_end    = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // Insert slot: a position below one acts as one, beyond the length as the length.
   always_comb begin
      pos_ext = SUM_W'(req_data.position);
      cnt_ext = SUM_W'(count_ff);
      after_n = (pos_ext == '0) ? SUM_W'(1) : pos_ext;
      if (after_n > cnt_ext) begin
         after_n = cnt_ext;
      end
      case (req_data.cmd)
         CMD_END:   ins_slot = count_idx;
         CMD_BEGIN: ins_slot = '0;
         default:   ins_slot = IDX_W'(after_n);
      endcase
   end

   // Sequencer next state and store access.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      slot_in   = slot_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      rsp_load  = 1'b0;
      rsp_beat  = '{item: '0, status: status_ff, last: 1'b1};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in = req_data.value;
               unique case (req_data.cmd) inside
                  CMD_END, CMD_BEGIN, CMD_AFTER: begin
                     if (list_full) begin
                        status_in = STAT_FULL;
                        state_in  = S_EMIT;
                     end else begin
                        slot_in = ins_slot;
                        if (ins_slot == count_idx) begin
                           state_in = S_INS_PUT;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = count_idx - IDX_W'(1);
                           idx_in   = count_idx - IDX_W'(1);
                           state_in = S_INS_MOVE;
                        end
                     end
                  end
                  CMD_DELETE, CMD_READ: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = S_EMIT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = (req_data.cmd == CMD_READ) ? S_RD_OUT : S_DEL_SCAN;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                     state_in  = S_EMIT;
                  end
               endcase
            end
         end

         // Single result beat of a command.
         S_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         // Move entries up by one, from the end down to the insert slot.
         S_INS_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + IDX_W'(1);
            if (idx_ff == slot_ff) begin
               state_in = S_INS_PUT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff - IDX_W'(1);
               idx_in  = idx_ff - IDX_W'(1);
            end
         end

         S_INS_PUT: begin
            wr_en     = 1'b1;
            wr_addr   = slot_ff;
            wr_data   = value_ff;
            count_in  = count_ff + CNT_W'(1);
            status_in = STAT_OK;
            state_in  = S_EMIT;
         end

         // Look for the first entry equal to the value.
         S_DEL_SCAN: begin
            if (rd_data == value_ff) begin
               if (at_end) begin
                  count_in  = count_ff - CNT_W'(1);
                  status_in = STAT_OK;
                  state_in  = S_EMIT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = idx_ff + IDX_W'(1);
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_DEL_MOVE;
               end
            end else if (at_end) begin
               status_in = STAT_MISSING;
               state_in  = S_EMIT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + IDX_W'(1);
               idx_in  = idx_ff + IDX_W'(1);
            end
         end

         // Close the gap: move each later entry down by one.
         S_DEL_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - IDX_W'(1);
            if (at_end) begin
               count_in  = count_ff - CNT_W'(1);
               status_in = STAT_OK;
               state_in  = S_EMIT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + IDX_W'(1);
               idx_in  = idx_ff + IDX_W'(1);
            end
         end

         // One beat per entry; the read data holds while the output stalls.
         S_RD_OUT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_beat = '{item: rd_data, status: STAT_OK, last: at_end};
               if (at_end) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + IDX_W'(1);
                  idx_in  = idx_ff + IDX_W'(1);
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register next value.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in  = rsp_beat;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      slot_ff     <= slot_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
